### design/psc_pkg.sv
package psc_pkg;

	localparam int unsigned PC_BITS = 5;

	localparam logic [12:0] ECHO_SCALE = 13'd4457;
	localparam logic [7:0] KEEP_WEIGHT = 8'd179;
	localparam logic [7:0] DRIFT_WEIGHT = 8'd243;
	localparam logic [6:0] NEW_WEIGHT = 7'd77;
	localparam logic [23:0] DRIFT_BIAS = 24'd665600;
	localparam logic [17:0] MIN_FRESH = 18'd512;
	localparam logic [15:0] DIST_RESET = 16'd51200;
	localparam logic [3:0] CHAOS_MARGIN = 4'd5;
	localparam logic [4:0] DIV_STEPS = 5'd24;

	localparam logic [7:0] NEAR_RESET = 8'd10;
	localparam logic [7:0] FAR_RESET = 8'd150;
	localparam logic [15:0] FAST_RESET = 16'd30;
	localparam logic [15:0] SLOW_RESET = 16'd500;
	localparam logic [7:0] DIM_RESET = 8'd5;
	localparam logic [7:0] FULL_RESET = 8'd255;
	localparam logic [7:0] BUZZ_RESET = 8'd40;

	typedef enum logic [2:0] {
		REG_NEAR,
		REG_FAR,
		REG_FAST,
		REG_SLOW,
		REG_DIM,
		REG_FULL,
		REG_BUZZ
	} reg_idx_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ACTIVE,
		ST_CHAOS
	} status_t;

	typedef struct packed {
		logic [7:0] near;
		logic [7:0] far;
		logic [15:0] fast;
		logic [15:0] slow;
		logic [7:0] dim;
		logic [7:0] full;
		logic [7:0] buzz;
	} cfg_t;

	typedef enum logic [4:0] {
		OP_NOP,
		OP_ACCEPT,
		OP_TICK,
		OP_ECHO_MUL,
		OP_FRESH,
		OP_FILT_A,
		OP_FILT_B,
		OP_FILT_SUM,
		OP_INT_MUL,
		OP_DIV_INIT,
		OP_DIV_STEP,
		OP_INT_SUM,
		OP_INT_CLAMP,
		OP_BRT_MUL,
		OP_BRT_SUM,
		OP_BRT_CLAMP,
		OP_STROBE,
		OP_OFF,
		OP_EMIT
	} op_t;

	typedef enum logic [2:0] {
		C_NEVER,
		C_ALWAYS,
		C_NO_INPUT,
		C_IS_TICK,
		C_OUT_RANGE,
		C_DIV_MORE,
		C_OUT_BUSY
	} cond_t;

	typedef struct packed {
		op_t op;
		cond_t cond;
		logic [PC_BITS-1:0] target;
	} uword_t;

	typedef struct packed {
		logic no_input;
		logic is_tick;
		logic out_range;
		logic div_more;
		logic out_busy;
	} flags_t;

	localparam logic [PC_BITS-1:0] A_ACCEPT = 5'd0;
	localparam logic [PC_BITS-1:0] A_RANGE = 5'd7;
	localparam logic [PC_BITS-1:0] A_DIV_INT = 5'd9;
	localparam logic [PC_BITS-1:0] A_DIV_BRT = 5'd14;
	localparam logic [PC_BITS-1:0] A_OFF = 5'd18;
	localparam logic [PC_BITS-1:0] A_EMIT = 5'd19;

	function automatic uword_t mk_uword(input op_t op, input cond_t cond,
		input logic [PC_BITS-1:0] target);
		uword_t w;
		w.op = op;
		w.cond = cond;
		w.target = target;
		return w;
	endfunction

	function automatic uword_t ucode_rom(input logic [PC_BITS-1:0] addr);
		uword_t w;
		case (addr)
			5'd0: w = mk_uword(OP_ACCEPT, C_NO_INPUT, A_ACCEPT);
			5'd1: w = mk_uword(OP_TICK, C_IS_TICK, A_RANGE);
			5'd2: w = mk_uword(OP_ECHO_MUL, C_NEVER, A_ACCEPT);
			5'd3: w = mk_uword(OP_FRESH, C_NEVER, A_ACCEPT);
			5'd4: w = mk_uword(OP_FILT_A, C_NEVER, A_ACCEPT);
			5'd5: w = mk_uword(OP_FILT_B, C_NEVER, A_ACCEPT);
			5'd6: w = mk_uword(OP_FILT_SUM, C_NEVER, A_ACCEPT);
			5'd7: w = mk_uword(OP_INT_MUL, C_OUT_RANGE, A_OFF);
			5'd8: w = mk_uword(OP_DIV_INIT, C_NEVER, A_ACCEPT);
			5'd9: w = mk_uword(OP_DIV_STEP, C_DIV_MORE, A_DIV_INT);
			5'd10: w = mk_uword(OP_INT_SUM, C_NEVER, A_ACCEPT);
			5'd11: w = mk_uword(OP_INT_CLAMP, C_NEVER, A_ACCEPT);
			5'd12: w = mk_uword(OP_BRT_MUL, C_NEVER, A_ACCEPT);
			5'd13: w = mk_uword(OP_DIV_INIT, C_NEVER, A_ACCEPT);
			5'd14: w = mk_uword(OP_DIV_STEP, C_DIV_MORE, A_DIV_BRT);
			5'd15: w = mk_uword(OP_BRT_SUM, C_NEVER, A_ACCEPT);
			5'd16: w = mk_uword(OP_BRT_CLAMP, C_NEVER, A_ACCEPT);
			5'd17: w = mk_uword(OP_STROBE, C_ALWAYS, A_EMIT);
			5'd18: w = mk_uword(OP_OFF, C_NEVER, A_ACCEPT);
			5'd19: w = mk_uword(OP_EMIT, C_OUT_BUSY, A_EMIT);
			default: w = mk_uword(OP_NOP, C_ALWAYS, A_ACCEPT);
		endcase
		return w;
	endfunction

endpackage

### design/psc_sequencer.sv
module psc_sequencer (
	input  logic            clk,
	input  logic            arst_n,
	input  psc_pkg::flags_t flags,
	output psc_pkg::op_t    op
);
	import psc_pkg::*;

	logic [PC_BITS-1:0] pc_q;
	uword_t uw;
	logic take;

	assign uw = ucode_rom(pc_q);
	assign op = uw.op;

	always_comb begin
		case (uw.cond)
			C_NEVER: take = 1'b0;
			C_ALWAYS: take = 1'b1;
			C_NO_INPUT: take = flags.no_input;
			C_IS_TICK: take = flags.is_tick;
			C_OUT_RANGE: take = flags.out_range;
			C_DIV_MORE: take = flags.div_more;
			C_OUT_BUSY: take = flags.out_busy;
			default: take = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= A_ACCEPT;
		end else if (take) begin
			pc_q <= uw.target;
		end else begin
			pc_q <= pc_q + 1'b1;
		end
	end

endmodule

### design/psc_datapath.sv
module psc_datapath #(
	parameter int unsigned ELAPSED_BITS = 16
) (
	input  logic            clk,
	input  logic            arst_n,
	input  psc_pkg::op_t    op,
	input  psc_pkg::cfg_t   cfg,
	output psc_pkg::flags_t flags,
	input  logic            in_valid,
	output logic            in_ready,
	input  logic            command,
	input  logic [14:0]     echo_us,
	output logic            out_valid,
	input  logic            out_ready,
	output logic [7:0]      pwm_level,
	output logic            buzzer_on,
	output logic [1:0]      status,
	output logic [7:0]      distance_cm
);
	import psc_pkg::*;

	localparam int unsigned CMP_BITS = (ELAPSED_BITS > 16) ? ELAPSED_BITS : 16;

	logic cmd_q;
	logic [14:0] echo_q;
	logic [15:0] fd_q;
	logic [ELAPSED_BITS-1:0] elapsed_q;
	logic phase_q;
	logic [7:0] pwm_hold_q;
	logic buz_hold_q;
	logic signed [35:0] prod_q;
	logic [23:0] sum_q;
	logic [15:0] fresh_q;
	logic acc_q;
	logic [23:0] quo_q;
	logic [7:0] rem_q;
	logic [4:0] dcnt_q;
	logic neg_q;
	logic signed [25:0] mapped_q;
	logic [15:0] interval_q;
	logic [7:0] bright_q;
	logic out_valid_q;
	logic [7:0] out_pwm_q;
	logic out_buz_q;
	status_t out_status_q;
	logic [7:0] out_dist_q;

	logic [15:0] far_fx;
	logic signed [8:0] span;
	logic [8:0] span_neg;
	logic [7:0] span_mag;
	logic span_zero;
	logic signed [8:0] cm_off;
	logic signed [16:0] int_diff;
	logic signed [8:0] brt_diff;
	logic signed [17:0] mul_a;
	logic signed [17:0] mul_b;
	logic signed [35:0] product;
	logic [17:0] fresh18;
	logic [35:0] prod_abs;
	logic [8:0] shifted;
	logic [9:0] trial;
	logic [24:0] filt_total;
	logic signed [25:0] q_ext;
	logic signed [25:0] map_base;
	logic signed [25:0] map_sum;
	logic signed [25:0] clamp_lo;
	logic signed [25:0] clamp_hi;
	logic signed [25:0] clamp_val;
	logic toggle;
	logic new_phase;
	logic buz_near;
	logic [8:0] near5;
	logic chaos;
	logic in_range;
	status_t status_next;
	logic emit_fire;

	assign far_fx = {cfg.far, 8'h00};
	assign span = $signed({1'b0, cfg.far}) - $signed({1'b0, cfg.near});
	assign span_neg = 9'(-span);
	assign span_mag = span[8] ? span_neg[7:0] : span[7:0];
	assign span_zero = (span == 9'sd0);
	assign cm_off = $signed({1'b0, fd_q[15:8]}) - $signed({1'b0, cfg.near});
	assign int_diff = $signed({1'b0, cfg.slow}) - $signed({1'b0, cfg.fast});
	assign brt_diff = $signed({1'b0, cfg.dim}) - $signed({1'b0, cfg.full});

	// shared multiplier operand selection
	always_comb begin
		case (op)
			OP_ECHO_MUL: begin
				mul_a = {3'b000, echo_q};
				mul_b = {5'b00000, ECHO_SCALE};
			end
			OP_FILT_A: begin
				mul_a = {2'b00, fd_q};
				mul_b = {10'b0, (acc_q ? KEEP_WEIGHT : DRIFT_WEIGHT)};
			end
			OP_FILT_B: begin
				mul_a = {2'b00, fresh_q};
				mul_b = {11'b0, NEW_WEIGHT};
			end
			OP_INT_MUL: begin
				mul_a = {{9{cm_off[8]}}, cm_off};
				mul_b = {int_diff[16], int_diff};
			end
			OP_BRT_MUL: begin
				mul_a = {{9{cm_off[8]}}, cm_off};
				mul_b = {{9{brt_diff[8]}}, brt_diff};
			end
			default: begin
				mul_a = 18'sd0;
				mul_b = 18'sd0;
			end
		endcase
	end

	assign product = mul_a * mul_b;

	assign fresh18 = prod_q[27:10];
	assign prod_abs = prod_q[35] ? 36'(-prod_q) : prod_q;
	assign shifted = {rem_q, quo_q[23]};
	assign trial = {1'b0, shifted} - {2'b00, span_mag};
	assign filt_total = {1'b0, sum_q} + {1'b0, prod_q[23:0]};

	assign q_ext = $signed({2'b00, quo_q});
	assign map_base = (op == OP_INT_SUM) ? $signed({10'b0, cfg.fast})
		: $signed({18'b0, cfg.full});
	assign map_sum = span_zero ? map_base : (neg_q ? map_base - q_ext : map_base + q_ext);

	assign clamp_lo = (op == OP_INT_CLAMP) ? $signed({10'b0, cfg.fast})
		: $signed({18'b0, cfg.dim});
	assign clamp_hi = (op == OP_INT_CLAMP) ? $signed({10'b0, cfg.slow})
		: $signed({18'b0, cfg.full});
	assign clamp_val = (mapped_q < clamp_lo) ? clamp_lo
		: ((mapped_q > clamp_hi) ? clamp_hi : mapped_q);

	assign toggle = CMP_BITS'(interval_q) <= CMP_BITS'(elapsed_q);
	assign new_phase = ~phase_q;
	assign buz_near = fd_q < {cfg.buzz, 8'h00};
	assign near5 = {1'b0, cfg.near} + 9'(CHAOS_MARGIN);
	assign chaos = {1'b0, fd_q} < {near5, 8'h00};
	assign in_range = fd_q <= far_fx;
	assign status_next = chaos ? ST_CHAOS : (in_range ? ST_ACTIVE : ST_IDLE);
	assign emit_fire = (op == OP_EMIT) && (!out_valid_q || out_ready);

	assign flags.no_input = !in_valid;
	assign flags.is_tick = !cmd_q;
	assign flags.out_range = !in_range;
	assign flags.div_more = (dcnt_q != 5'd1);
	assign flags.out_busy = out_valid_q && !out_ready;

	assign in_ready = (op == OP_ACCEPT);
	assign out_valid = out_valid_q;
	assign pwm_level = out_pwm_q;
	assign buzzer_on = out_buz_q;
	assign status = out_status_q;
	assign distance_cm = out_dist_q;

	// filter and strobe state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fd_q <= DIST_RESET;
			elapsed_q <= '0;
			phase_q <= 1'b0;
			pwm_hold_q <= 8'd0;
			buz_hold_q <= 1'b0;
			dcnt_q <= 5'd0;
			out_valid_q <= 1'b0;
		end else begin
			case (op)
				OP_TICK: begin
					if (!cmd_q && (elapsed_q != {ELAPSED_BITS{1'b1}})) begin
						elapsed_q <= elapsed_q + 1'b1;
					end
				end
				OP_FILT_SUM: fd_q <= filt_total[23:8];
				OP_DIV_INIT: dcnt_q <= DIV_STEPS;
				OP_DIV_STEP: dcnt_q <= dcnt_q - 1'b1;
				OP_STROBE: begin
					if (toggle) begin
						elapsed_q <= '0;
						phase_q <= new_phase;
						pwm_hold_q <= new_phase ? bright_q : 8'd0;
						buz_hold_q <= buz_near ? new_phase : 1'b0;
					end
				end
				OP_OFF: begin
					pwm_hold_q <= 8'd0;
					buz_hold_q <= 1'b0;
				end
				default: begin
				end
			endcase
			if (emit_fire) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		case (op)
			OP_ACCEPT: begin
				if (in_valid) begin
					cmd_q <= command;
					echo_q <= echo_us;
				end
			end
			OP_ECHO_MUL, OP_FILT_A, OP_INT_MUL, OP_BRT_MUL: prod_q <= product;
			OP_FRESH: begin
				fresh_q <= fresh18[15:0];
				acc_q <= (fresh18 >= MIN_FRESH) && (fresh18 <= {2'b00, far_fx});
			end
			OP_FILT_B: begin
				sum_q <= prod_q[23:0];
				prod_q <= acc_q ? product : $signed({12'b0, DRIFT_BIAS});
			end
			OP_DIV_INIT: begin
				quo_q <= prod_abs[23:0];
				rem_q <= 8'd0;
				neg_q <= prod_q[35] ^ span[8];
			end
			OP_DIV_STEP: begin
				if (!trial[9]) begin
					rem_q <= trial[7:0];
					quo_q <= {quo_q[22:0], 1'b1};
				end else begin
					rem_q <= shifted[7:0];
					quo_q <= {quo_q[22:0], 1'b0};
				end
			end
			OP_INT_SUM, OP_BRT_SUM: mapped_q <= map_sum;
			OP_INT_CLAMP: interval_q <= clamp_val[15:0];
			OP_BRT_CLAMP: bright_q <= clamp_val[7:0];
			default: begin
			end
		endcase
		if (emit_fire) begin
			out_pwm_q <= pwm_hold_q;
			out_buz_q <= buz_hold_q;
			out_status_q <= status_next;
			out_dist_q <= fd_q[15:8];
		end
	end

endmodule

### design/proximity_strobe_controller.sv
// proximity strobe controller
// input channel (in_valid/in_ready): command 0 is a one millisecond tick,
// command 1 carries an echo width in echo_us. every input transaction yields
// exactly one output transaction with the held pwm level, buzzer level,
// status (0 idle, 1 active, 2 chaos) and filtered distance in cm.
// configuration channel (cfg_valid/cfg_ready, always ready): cfg_index picks
// the register, cfg_data carries the value; write only while idle.
// a microcoded sequencer steps one control word per cycle through a shared
// multiplier and a one bit per cycle divider run twice. an echo passes the
// filter steps first, a tick skips them; in range both then run the interval
// and brightness mappings and the strobe step, out of range they go to the
// off step. once the result is loaded the sequencer passes a nop step and
// returns to the accept step, so one item is done before the next is taken.
// the result sits in an output register; a stalled receiver does not block
// acceptance of the next item, which waits at its final step only if the
// previous result is still not taken.
// reset: registers take their default values, filtered distance is 200 cm,
// strobe, pwm, buzzer and millisecond count are cleared, no output pending.
module proximity_strobe_controller #(
	parameter int unsigned ELAPSED_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        command,
	input  logic [14:0] echo_us,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  pwm_level,
	output logic        buzzer_on,
	output logic [1:0]  status,
	output logic [7:0]  distance_cm,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data
);
	import psc_pkg::*;

	cfg_t cfg_q;
	flags_t flags;
	op_t op;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.near <= NEAR_RESET;
			cfg_q.far <= FAR_RESET;
			cfg_q.fast <= FAST_RESET;
			cfg_q.slow <= SLOW_RESET;
			cfg_q.dim <= DIM_RESET;
			cfg_q.full <= FULL_RESET;
			cfg_q.buzz <= BUZZ_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_NEAR: cfg_q.near <= cfg_data[7:0];
				REG_FAR: cfg_q.far <= cfg_data[7:0];
				REG_FAST: cfg_q.fast <= cfg_data;
				REG_SLOW: cfg_q.slow <= cfg_data;
				REG_DIM: cfg_q.dim <= cfg_data[7:0];
				REG_FULL: cfg_q.full <= cfg_data[7:0];
				REG_BUZZ: cfg_q.buzz <= cfg_data[7:0];
				default: begin
				end
			endcase
		end
	end

	psc_sequencer u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.flags  (flags),
		.op     (op)
	);

	psc_datapath #(
		.ELAPSED_BITS (ELAPSED_BITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.op          (op),
		.cfg         (cfg_q),
		.flags       (flags),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.command     (command),
		.echo_us     (echo_us),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.pwm_level   (pwm_level),
		.buzzer_on   (buzzer_on),
		.status      (status),
		.distance_cm (distance_cm)
	);

	// one item in flight: no second acceptance right after one
	a_single_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("input accepted on consecutive cycles");

	// a result is only loaded while the sequencer is not at its accept step
	a_emit_not_accept: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !$past(in_ready))
		else $error("result loaded during accept step");

	// beyond activation distance the strobe outputs are off
	a_idle_dark: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == ST_IDLE) |-> (pwm_level == 8'd0 && !buzzer_on))
		else $error("pwm or buzzer active while idle");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (status != 2'd3))
		else $error("undefined status code");

endmodule
